// File: sv/load_risk_mode_governor_unit_macros.svh
`ifndef LOAD_RISK_MODE_GOVERNOR_UNIT_MACROS_SVH
`define LOAD_RISK_MODE_GOVERNOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define LRMG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while in reset.
`define LRMG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lrmg_pkg.sv
package lrmg_pkg;

  localparam int unsigned PCT_W       = 7;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned SHARE_FRAC  = 16;
  localparam int unsigned SHARE_W     = SHARE_FRAC + 1;
  localparam int unsigned TOTAL_W     = PCT_W + 2;
  localparam int unsigned DIV_STEPS   = PCT_W + SHARE_FRAC;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  localparam logic [PCT_W-1:0] RISK_MAX = PCT_W'(100);

  typedef enum logic [2:0] {
    REG_HIGH_LOAD_THR  = 3'd0,
    REG_SURGE_LOAD_THR = 3'd1,
    REG_SURGE_RISK_LIM = 3'd2,
    REG_UNTRUSTED_RISE = 3'd3,
    REG_TRUSTED_RISE   = 3'd4,
    REG_RISK_DECAY     = 3'd5,
    REG_LEVEL_FLOOR    = 3'd6,
    REG_UNUSED         = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_STEADY = 2'd0,
    MODE_BRACE  = 2'd1,
    MODE_SURGE  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [PCT_W-1:0] high_load_threshold;
    logic [PCT_W-1:0] surge_load_threshold;
    logic [PCT_W-1:0] surge_risk_limit;
    logic [PCT_W-1:0] untrusted_rise;
    logic [PCT_W-1:0] trusted_rise;
    logic [PCT_W-1:0] risk_decay;
    logic [PCT_W-1:0] level_floor;
  } cfg_t;

  typedef struct packed {
    logic [PCT_W-1:0] load_percent;
    logic             trusted;
  } in_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]  tick_number;
    logic [PCT_W-1:0]   risk_now;
    logic [SHARE_W-1:0] steady_share;
    logic [SHARE_W-1:0] brace_share;
    logic [SHARE_W-1:0] surge_share;
    logic [1:0]         mode;
  } out_item_t;

  // classified tick waiting for the share divisions
  typedef struct packed {
    logic [TICK_W-1:0]  tick_number;
    logic [PCT_W-1:0]   risk_now;
    logic [PCT_W-1:0]   steady;
    logic [PCT_W-1:0]   brace;
    logic [PCT_W-1:0]   surge;
    logic [TOTAL_W-1:0] total;
    logic [1:0]         mode;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: sv/lrmg_front.sv
`include "load_risk_mode_governor_unit_macros.svh"

module lrmg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  lrmg_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  lrmg_pkg::in_item_t  in_data,
  input  lrmg_pkg::fifo_stat_t fifo_stat,
  output logic                push,
  output lrmg_pkg::entry_t    push_data
);

  logic [lrmg_pkg::PCT_W-1:0]   risk_r, risk_nxt;
  logic [lrmg_pkg::TICK_W-1:0]  tick_r, tick_nxt;
  logic [lrmg_pkg::PCT_W-1:0]   load_sat, step, risk_up, risk_dn;
  logic [lrmg_pkg::PCT_W:0]     rise_sum;
  logic [lrmg_pkg::PCT_W-1:0]   steady_raw, surge_raw;
  logic [lrmg_pkg::PCT_W-1:0]   steady_lv, brace_lv, surge_lv;
  logic                         high_load;
  lrmg_pkg::mode_e              mode;

  assign in_stall = fifo_stat.full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    load_sat  = (in_data.load_percent > lrmg_pkg::RISK_MAX) ? lrmg_pkg::RISK_MAX
                                                             : in_data.load_percent;
    high_load = load_sat > cfg.high_load_threshold;
    step      = in_data.trusted ? cfg.trusted_rise : cfg.untrusted_rise;
    rise_sum  = {1'b0, risk_r} + {1'b0, step};
    risk_up   = (rise_sum > {1'b0, lrmg_pkg::RISK_MAX}) ? lrmg_pkg::RISK_MAX
                                                        : rise_sum[lrmg_pkg::PCT_W-1:0];
    risk_dn   = (risk_r > cfg.risk_decay) ? risk_r - cfg.risk_decay : '0;
    risk_nxt  = high_load ? risk_up : risk_dn;
    tick_nxt  = tick_r + 1'b1;

    steady_raw = lrmg_pkg::RISK_MAX - risk_nxt;
    surge_raw  = (load_sat > cfg.surge_load_threshold && risk_nxt < cfg.surge_risk_limit
                  && in_data.trusted) ? load_sat : '0;

    steady_lv = (steady_raw < cfg.level_floor) ? cfg.level_floor : steady_raw;
    brace_lv  = (risk_nxt   < cfg.level_floor) ? cfg.level_floor : risk_nxt;
    surge_lv  = (surge_raw  < cfg.level_floor) ? cfg.level_floor : surge_raw;

    priority if (brace_lv > steady_lv && brace_lv > surge_lv) begin
      mode = lrmg_pkg::MODE_BRACE;
    end else if (surge_lv > steady_lv) begin
      mode = lrmg_pkg::MODE_SURGE;
    end else begin
      mode = lrmg_pkg::MODE_STEADY;
    end

    push_data.tick_number = tick_nxt;
    push_data.risk_now    = risk_nxt;
    push_data.steady      = steady_lv;
    push_data.brace       = brace_lv;
    push_data.surge       = surge_lv;
    push_data.total       = {2'b00, steady_lv} + {2'b00, brace_lv} + {2'b00, surge_lv};
    push_data.mode        = mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      risk_r <= '0;
      tick_r <= '0;
    end else if (push) begin
      risk_r <= risk_nxt;
      tick_r <= tick_nxt;
    end
  end

  `LRMG_ASSERT_NOW(a_risk_range, 1'b1, risk_r <= lrmg_pkg::RISK_MAX, "risk out of range")
  `LRMG_ASSERT_NEXT(a_tick_step, push, tick_r == $past(tick_r) + 1'b1, "tick not advanced")
  `LRMG_ASSERT_NOW(a_total_floor, push, push_data.total >= lrmg_pkg::TOTAL_W'(100),
                   "level total below 100")

endmodule

// File: sv/lrmg_fifo.sv
module lrmg_fifo #(
  parameter int unsigned DEPTH = lrmg_pkg::FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lrmg_pkg::entry_t     push_data,
  input  logic                 pop,
  output lrmg_pkg::entry_t     pop_data,
  output lrmg_pkg::fifo_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lrmg_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == CNT_W'(DEPTH);
  assign stat.empty = cnt_r == '0;
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/lrmg_back.sv
`include "load_risk_mode_governor_unit_macros.svh"

module lrmg_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lrmg_pkg::fifo_stat_t fifo_stat,
  input  lrmg_pkg::entry_t     pop_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lrmg_pkg::out_item_t  out_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam int unsigned DVD_W = lrmg_pkg::DIV_STEPS;
  localparam int unsigned SH_W  = lrmg_pkg::SHARE_W;
  localparam int unsigned TT_W  = lrmg_pkg::TOTAL_W;

  typedef enum logic [1:0] {
    SEL_STEADY = 2'd0,
    SEL_BRACE  = 2'd1,
    SEL_SURGE  = 2'd2,
    SEL_NONE   = 2'd3
  } sel_t;

  state_t                          state_r, state_nxt;
  sel_t                            sel_r;
  logic [lrmg_pkg::DIV_CNT_W-1:0]  cnt_r;
  lrmg_pkg::entry_t                ent_r;
  logic [DVD_W-1:0]                dvd_r;
  logic [TT_W-1:0]                 rem_r;
  logic [SH_W-1:0]                 quo_r;
  logic [SH_W-1:0]                 steady_sh_r, brace_sh_r, surge_sh_r;
  logic [TT_W:0]                   trial;
  logic                            q_bit;
  logic [TT_W-1:0]                 rem_step;
  logic [SH_W-1:0]                 quo_step;
  logic                            out_valid_r;
  lrmg_pkg::out_item_t             out_data_r;
  logic                            out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (state_r == S_IDLE) && !fifo_stat.empty;

  // restoring division step, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, dvd_r[DVD_W-1]};
    q_bit    = trial >= {1'b0, ent_r.total};
    rem_step = q_bit ? TT_W'(trial - {1'b0, ent_r.total}) : trial[TT_W-1:0];
    quo_step = {quo_r[SH_W-2:0], q_bit};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!fifo_stat.empty) state_nxt = S_DIV;
      S_DIV:  if (cnt_r == '0 && sel_r == SEL_SURGE) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sel_r       <= SEL_STEADY;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        sel_r <= SEL_STEADY;
        cnt_r <= lrmg_pkg::DIV_CNT_W'(DVD_W - 1);
      end else if (state_r == S_DIV) begin
        if (cnt_r == '0) begin
          cnt_r <= lrmg_pkg::DIV_CNT_W'(DVD_W - 1);
          sel_r <= (sel_r == SEL_STEADY) ? SEL_BRACE : SEL_SURGE;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= pop_data;
      dvd_r <= {pop_data.steady, lrmg_pkg::SHARE_FRAC'(0)};
      rem_r <= '0;
      quo_r <= '0;
    end else if (state_r == S_DIV) begin
      if (cnt_r == '0) begin
        rem_r <= '0;
        quo_r <= '0;
        unique case (sel_r)
          SEL_STEADY: begin
            steady_sh_r <= quo_step;
            dvd_r       <= {ent_r.brace, lrmg_pkg::SHARE_FRAC'(0)};
          end
          SEL_BRACE: begin
            brace_sh_r <= quo_step;
            dvd_r      <= {ent_r.surge, lrmg_pkg::SHARE_FRAC'(0)};
          end
          SEL_SURGE: begin
            surge_sh_r <= quo_step;
          end
          default: begin
          end
        endcase
      end else begin
        rem_r <= rem_step;
        quo_r <= quo_step;
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      end
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r.tick_number  <= ent_r.tick_number;
      out_data_r.risk_now     <= ent_r.risk_now;
      out_data_r.steady_share <= steady_sh_r;
      out_data_r.brace_share  <= brace_sh_r;
      out_data_r.surge_share  <= surge_sh_r;
      out_data_r.mode         <= ent_r.mode;
    end
  end

  `LRMG_ASSERT_NOW(a_sel_range, state_r == S_DIV, sel_r != SEL_NONE, "bad share select")
  `LRMG_ASSERT_NEXT(a_out_load, state_r == S_DONE && out_free,
                    out_valid && out_data.steady_share + out_data.brace_share
                    + out_data.surge_share <= SH_W'(65536), "share sum exceeds one")
  `LRMG_ASSERT_NOW(a_pop_idle, pop, state_r == S_IDLE && !fifo_stat.empty,
                   "pop outside idle")

endmodule

// File: sv/load_risk_mode_governor_unit.sv
// From input transfer to result valid, the tick is written into the queue, three
// 23-step restoring divisions run on one shared divider, and the output register
// is loaded.
// The divider takes no new tick until the last result is in the output register.
// The front accepts while the queue has room, so short bursts are absorbed.
// Reset (rst_n low, synchronous): risk and tick counter cleared, registers reload
// their defaults, queue and output register emptied.
module load_risk_mode_governor_unit #(
  parameter int unsigned FIFO_DEPTH = lrmg_pkg::FIFO_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lrmg_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lrmg_pkg::out_item_t       out_data,
  input  logic                      cfg_we,
  input  lrmg_pkg::reg_idx_e        cfg_idx,
  input  logic [lrmg_pkg::PCT_W-1:0] cfg_wdata
);

  lrmg_pkg::cfg_t       cfg_r;
  lrmg_pkg::fifo_stat_t fifo_stat;
  lrmg_pkg::entry_t     push_data, pop_data;
  logic                 push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_load_threshold  <= lrmg_pkg::PCT_W'(80);
      cfg_r.surge_load_threshold <= lrmg_pkg::PCT_W'(50);
      cfg_r.surge_risk_limit     <= lrmg_pkg::PCT_W'(40);
      cfg_r.untrusted_rise       <= lrmg_pkg::PCT_W'(20);
      cfg_r.trusted_rise         <= lrmg_pkg::PCT_W'(5);
      cfg_r.risk_decay           <= lrmg_pkg::PCT_W'(10);
      cfg_r.level_floor          <= lrmg_pkg::PCT_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lrmg_pkg::REG_HIGH_LOAD_THR:  cfg_r.high_load_threshold  <= cfg_wdata;
        lrmg_pkg::REG_SURGE_LOAD_THR: cfg_r.surge_load_threshold <= cfg_wdata;
        lrmg_pkg::REG_SURGE_RISK_LIM: cfg_r.surge_risk_limit     <= cfg_wdata;
        lrmg_pkg::REG_UNTRUSTED_RISE: cfg_r.untrusted_rise       <= cfg_wdata;
        lrmg_pkg::REG_TRUSTED_RISE:   cfg_r.trusted_rise         <= cfg_wdata;
        lrmg_pkg::REG_RISK_DECAY:     cfg_r.risk_decay           <= cfg_wdata;
        lrmg_pkg::REG_LEVEL_FLOOR:    cfg_r.level_floor          <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lrmg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data)
  );

  lrmg_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  lrmg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: test/tb.sv
module tb;

  localparam int DIR_N           = 25;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int LONG_HOLD       = 600;
  localparam int DRAIN_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTS     = 10;

  localparam lrmg_pkg::cfg_t GOV_DEFAULTS = '{7'd80, 7'd50, 7'd40, 7'd20, 7'd5, 7'd10, 7'd5};

  typedef struct packed {
    lrmg_pkg::in_item_t  tick;
    logic                typed;
    lrmg_pkg::out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lrmg_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lrmg_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  lrmg_pkg::reg_idx_e cfg_idx = lrmg_pkg::REG_HIGH_LOAD_THR;
  logic [lrmg_pkg::PCT_W-1:0] cfg_wdata = '0;

  // governor state as the block should hold it
  lrmg_pkg::cfg_t gov_cfg = GOV_DEFAULTS;
  int unsigned risk_pct = 0;
  logic [lrmg_pkg::TICK_W-1:0] tick_cnt = '0;

  lrmg_pkg::out_item_t pending_results[$];
  lrmg_pkg::out_item_t want_r;

  int mismatches = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int settings_used = 1;
  int rx_holds = 0;
  int mode_hits[3] = '{0, 0, 0};
  int idle_cycles = 0;
  int regime = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit rx_hold_req = 1'b0;

  // first two rows worked out by hand from the reset settings
  dir_row_t dir_rows [DIR_N] = '{
    '{'{7'd0,   1'b0}, 1'b1,
      '{32'd1, 7'd0, 17'd59578, 17'd2978, 17'd2978, lrmg_pkg::MODE_STEADY}},
    '{'{7'd127, 1'b1}, 1'b1,
      '{32'd2, 7'd5, 17'd31129, 17'd1638, 17'd32768, lrmg_pkg::MODE_SURGE}},
    '{'{7'd101, 1'b0}, 1'b0, '0},  // load above range, untrusted rise
    '{'{7'd100, 1'b0}, 1'b0, '0},
    '{'{7'd100, 1'b0}, 1'b0, '0},  // brace takes over
    '{'{7'd100, 1'b0}, 1'b0, '0},
    '{'{7'd100, 1'b1}, 1'b0, '0},
    '{'{7'd127, 1'b0}, 1'b0, '0},  // risk saturates
    '{'{7'd81,  1'b0}, 1'b0, '0},
    '{'{7'd80,  1'b1}, 1'b0, '0},  // load at threshold is not high
    '{'{7'd0,   1'b0}, 1'b0, '0},
    '{'{7'd0,   1'b1}, 1'b0, '0},
    '{'{7'd50,  1'b0}, 1'b0, '0},
    '{'{7'd50,  1'b1}, 1'b0, '0},  // steady and brace tie
    '{'{7'd60,  1'b1}, 1'b0, '0},  // risk at surge limit blocks surge
    '{'{7'd70,  1'b1}, 1'b0, '0},  // surge ties steady
    '{'{7'd51,  1'b1}, 1'b0, '0},
    '{'{7'd50,  1'b1}, 1'b0, '0},  // load at surge threshold
    '{'{7'd99,  1'b1}, 1'b0, '0},
    '{'{7'd100, 1'b0}, 1'b0, '0},
    '{'{7'd0,   1'b0}, 1'b0, '0},
    '{'{7'd0,   1'b0}, 1'b0, '0},
    '{'{7'd0,   1'b0}, 1'b0, '0},
    '{'{7'd0,   1'b0}, 1'b0, '0},  // decay floors at zero
    '{'{7'd1,   1'b1}, 1'b0, '0}
  };

  load_risk_mode_governor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic void set_gov_reg(lrmg_pkg::reg_idx_e idx, logic [lrmg_pkg::PCT_W-1:0] v);
    case (idx)
      lrmg_pkg::REG_HIGH_LOAD_THR:  gov_cfg.high_load_threshold = v;
      lrmg_pkg::REG_SURGE_LOAD_THR: gov_cfg.surge_load_threshold = v;
      lrmg_pkg::REG_SURGE_RISK_LIM: gov_cfg.surge_risk_limit = v;
      lrmg_pkg::REG_UNTRUSTED_RISE: gov_cfg.untrusted_rise = v;
      lrmg_pkg::REG_TRUSTED_RISE:   gov_cfg.trusted_rise = v;
      lrmg_pkg::REG_RISK_DECAY:     gov_cfg.risk_decay = v;
      lrmg_pkg::REG_LEVEL_FLOOR:    gov_cfg.level_floor = v;
      default: ;
    endcase
  endfunction

  // advances risk and tick count, returns the result the block owes for this tick
  function automatic lrmg_pkg::out_item_t next_tick_result(lrmg_pkg::in_item_t t);
    lrmg_pkg::out_item_t r;
    int unsigned load, rise, steady, brace, surge, total, fl;
    load = t.load_percent;
    if (load > 100) load = 100;
    tick_cnt = tick_cnt + 1'b1;
    if (load > gov_cfg.high_load_threshold) begin
      rise = t.trusted ? gov_cfg.trusted_rise : gov_cfg.untrusted_rise;
      risk_pct = (risk_pct + rise > 100) ? 100 : risk_pct + rise;
    end else begin
      risk_pct = (risk_pct > gov_cfg.risk_decay) ? risk_pct - gov_cfg.risk_decay : 0;
    end
    brace = risk_pct;
    steady = 100 - risk_pct;
    surge = (load > gov_cfg.surge_load_threshold && risk_pct < gov_cfg.surge_risk_limit
             && t.trusted) ? load : 0;
    fl = gov_cfg.level_floor;
    if (steady < fl) steady = fl;
    if (brace < fl) brace = fl;
    if (surge < fl) surge = fl;
    total = steady + brace + surge;
    r.tick_number  = tick_cnt;
    r.risk_now     = lrmg_pkg::PCT_W'(risk_pct);
    r.steady_share = lrmg_pkg::SHARE_W'((64'(steady) << lrmg_pkg::SHARE_FRAC) / total);
    r.brace_share  = lrmg_pkg::SHARE_W'((64'(brace) << lrmg_pkg::SHARE_FRAC) / total);
    r.surge_share  = lrmg_pkg::SHARE_W'((64'(surge) << lrmg_pkg::SHARE_FRAC) / total);
    if (brace > steady && brace > surge) r.mode = lrmg_pkg::MODE_BRACE;
    else if (surge > steady) r.mode = lrmg_pkg::MODE_SURGE;
    else r.mode = lrmg_pkg::MODE_STEADY;
    return r;
  endfunction

  function automatic logic [lrmg_pkg::PCT_W-1:0] pick_pct();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return lrmg_pkg::PCT_W'(100);
      2: return '1;
      default: return lrmg_pkg::PCT_W'($urandom_range(100, 0));
    endcase
  endfunction

  // loads are drawn in runs so risk climbs, saturates and decays
  function automatic lrmg_pkg::in_item_t random_tick();
    lrmg_pkg::in_item_t t;
    int unsigned thr, lo, hi;
    thr = gov_cfg.high_load_threshold;
    lo = (thr < 3) ? 0 : thr - 3;
    hi = (thr + 3 > 127) ? 127 : thr + 3;
    case (regime)
      1: t.load_percent = (thr >= 127) ? '1
                                       : lrmg_pkg::PCT_W'($urandom_range(127, thr + 1));
      2: t.load_percent = lrmg_pkg::PCT_W'($urandom_range(thr, 0));
      3: t.load_percent = lrmg_pkg::PCT_W'($urandom_range(hi, lo));
      default: t.load_percent = lrmg_pkg::PCT_W'($urandom_range(127, 0));
    endcase
    t.trusted = 1'($urandom_range(1, 0));
    return t;
  endfunction

  // valid is only lowered when a gap follows, so back-to-back transfers keep it high
  task automatic send_tick(lrmg_pkg::in_item_t t, logic typed,
                           lrmg_pkg::out_item_t typed_want);
    lrmg_pkg::out_item_t pred;
    int gap;
    if ($urandom_range(23, 0) == 0) tx_calm = ~tx_calm;
    gap = tx_calm ? 0 : $urandom_range(7, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    pred = next_tick_result(t);
    pending_results.push_back(typed ? typed_want : pred);
    ticks_sent++;
  endtask

  task automatic write_reg(lrmg_pkg::reg_idx_e idx, logic [lrmg_pkg::PCT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    set_gov_reg(idx, v);
  endtask

  task automatic load_settings(lrmg_pkg::cfg_t s);
    write_reg(lrmg_pkg::REG_HIGH_LOAD_THR, s.high_load_threshold);
    write_reg(lrmg_pkg::REG_SURGE_LOAD_THR, s.surge_load_threshold);
    write_reg(lrmg_pkg::REG_SURGE_RISK_LIM, s.surge_risk_limit);
    write_reg(lrmg_pkg::REG_UNTRUSTED_RISE, s.untrusted_rise);
    write_reg(lrmg_pkg::REG_TRUSTED_RISE, s.trusted_rise);
    write_reg(lrmg_pkg::REG_RISK_DECAY, s.risk_decay);
    write_reg(lrmg_pkg::REG_LEVEL_FLOOR, s.level_floor);
    cfg_we <= 1'b0;
  endtask

  initial begin
    lrmg_pkg::cfg_t next_cfg;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(posedge clk);
        case (p)
          1: next_cfg = '0;
          2: next_cfg = '1;
          3: next_cfg = '{default: 7'd100};
          4: next_cfg = GOV_DEFAULTS;
          default: next_cfg = '{pick_pct(), pick_pct(), pick_pct(), pick_pct(),
                                 pick_pct(), pick_pct(), pick_pct()};
        endcase
        load_settings(next_cfg);
        settings_used++;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 10 == 0) regime = $urandom_range(3, 0);
        if (k == 30 && (p == 2 || p == 7)) rx_hold_req = 1'b1;
        if (k == 75) begin
          // let the block run dry mid-phase
          in_valid <= 1'b0;
          wait (pending_results.size() == 0);
        end
        send_tick(random_tick(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d ticks over %0d register settings, %0d results checked, %0d mismatches",
             ticks_sent, settings_used, results_seen, mismatches);
    $display("modes steady/brace/surge %0d/%0d/%0d, long output hold-offs %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], rx_holds);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** load_risk_mode_governor_unit: PASSED **");
    end else begin
      $display("** load_risk_mode_governor_unit: FAILED **");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_req) begin
        hold = LONG_HOLD;
        rx_hold_req = 1'b0;
        rx_holds++;
      end else begin
        if ($urandom_range(23, 0) == 0) rx_calm = ~rx_calm;
        hold = rx_calm ? 0 : $urandom_range(7, 0);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.mode <= lrmg_pkg::MODE_SURGE) mode_hits[out_data.mode]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transfer: tick %0d risk %0d", out_data.tick_number,
                   out_data.risk_now);
      end else begin
        want_r = pending_results.pop_front();
        if (out_data.tick_number !== want_r.tick_number || out_data.risk_now !== want_r.risk_now
            || out_data.steady_share !== want_r.steady_share
            || out_data.brace_share !== want_r.brace_share
            || out_data.surge_share !== want_r.surge_share || out_data.mode !== want_r.mode) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: want tick %0d risk %0d shares %0d/%0d/%0d mode %0d, got tick %0d risk %0d shares %0d/%0d/%0d mode %0d",
                     want_r.tick_number, want_r.risk_now, want_r.steady_share,
                     want_r.brace_share, want_r.surge_share, want_r.mode,
                     out_data.tick_number, out_data.risk_now, out_data.steady_share,
                     out_data.brace_share, out_data.surge_share, out_data.mode);
        end
      end
    end
  end

  // nothing moving for too long means the block is hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding", idle_cycles,
               pending_results.size());
      $display("** load_risk_mode_governor_unit: FAILED **");
      $finish;
    end
  end

endmodule
